### rtl/core/gtc_pkg.sv
// Shared types and constants for the graph triangle counter.
// Used by gtc_ctrl, gtc_dpath, graph_triangle_counter_unit and the sim files; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtc_pkg;

    localparam int VTX_W          = 6;
    localparam int COUNT_W        = 16;
    localparam int DEF_NODE_COUNT = 64;
    localparam int MAX_ROWS       = 1 << VTX_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_B,
        ST_ROW_RD,
        ST_ROW_LD,
        ST_COL_RD,
        ST_COL_AND,
        ST_COL_ADD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic wr_in;
        logic wr_back;
        logic start;
        logic rd_row;
        logic ld_row;
        logic rd_col;
        logic ld_and;
        logic acc_add;
        logic next_u;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic u_last;
        logic v_last;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/gtc_dpath.sv
// Datapath: adjacency row memory with per-row valid bits, row/column walk
// counters, AND/popcount accumulator and result register. Depends on gtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtc_dpath
    import gtc_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ctl_cmd_t           cmd,
    output dp_stat_t                stat,
    input  wire logic [VTX_W-1:0]   node_a,
    input  wire logic [VTX_W-1:0]   node_b,
    output logic [COUNT_W-1:0]      count
);

    localparam int ROWS   = (NODE_COUNT < MAX_ROWS) ? NODE_COUNT : MAX_ROWS;
    localparam int ADDR_W = $clog2(ROWS);
    localparam int PC_W   = $clog2(ROWS + 1);
    localparam logic [VTX_W:0]       ROWS_V = (VTX_W + 1)'(ROWS);
    localparam logic [ADDR_W-1:0]    LAST_A = ADDR_W'(ROWS - 1);
    localparam logic [COUNT_W-1:0]   CNT_MAX = '1;

    logic [ROWS-1:0]    mem [ROWS];
    logic [ROWS-1:0]    row_vld_reg;
    logic [ROWS-1:0]    rd_data_reg;
    logic               rd_vld_reg;
    logic [ROWS-1:0]    row_eff;

    logic [ADDR_W-1:0]  a_reg, b_reg;
    logic               ok_reg;
    logic               in_ok;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  wr_pos;
    logic [ROWS-1:0]    wr_bit;
    logic [ROWS-1:0]    wr_mask;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    logic [ADDR_W-1:0]  u_reg, v_reg;
    logic [ROWS-1:0]    row_u_reg;
    logic [ROWS-1:0]    and_reg;
    logic [ROWS-1:0]    above;
    logic [PC_W-1:0]    pc;
    logic [COUNT_W:0]   acc_sum;
    logic [COUNT_W-1:0] acc_reg;
    logic [COUNT_W-1:0] count_reg;

    assign in_ok = (node_a != node_b) && ({1'b0, node_a} < ROWS_V) && ({1'b0, node_b} < ROWS_V);

    // edge write: row a bit b on the transfer cycle, row b bit a the cycle after
    always_comb begin
        if (cmd.wr_in) begin
            wr_en   = in_ok;
            wr_addr = node_a[ADDR_W-1:0];
            wr_pos  = node_b[ADDR_W-1:0];
        end else begin
            wr_en   = cmd.wr_back && ok_reg;
            wr_addr = b_reg;
            wr_pos  = a_reg;
        end
        wr_bit  = ROWS'(1) << wr_pos;
        wr_mask = row_vld_reg[wr_addr] ? wr_bit : '1;
        rd_en   = cmd.rd_row || cmd.rd_col;
        rd_addr = cmd.rd_row ? u_reg : v_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int i = 0; i < ROWS; i++) begin
                if (wr_mask[i]) begin
                    mem[wr_addr][i] <= wr_bit[i];
                end
            end
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (cmd.load_out) begin
            row_vld_reg <= '0;
        end else if (wr_en) begin
            row_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_vld_reg <= row_vld_reg[rd_addr];
        end
        if (cmd.wr_in) begin
            a_reg  <= node_a[ADDR_W-1:0];
            b_reg  <= node_b[ADDR_W-1:0];
            ok_reg <= in_ok;
        end
    end

    assign row_eff = rd_vld_reg ? rd_data_reg : '0;

    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            above[i] = (i > int'(v_reg));
        end
        pc = '0;
        for (int i = 0; i < ROWS; i++) begin
            pc = pc + PC_W'(and_reg[i]);
        end
        acc_sum = {1'b0, acc_reg} + (COUNT_W + 1)'(pc);
    end

    // walk: u < v < w, each triangle seen once
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            u_reg   <= '0;
            acc_reg <= '0;
        end
        if (cmd.ld_row) begin
            row_u_reg <= row_eff;
            v_reg     <= u_reg + ADDR_W'(1);
        end
        if (cmd.ld_and) begin
            and_reg <= row_u_reg[v_reg] ? (row_u_reg & row_eff & above) : '0;
        end
        if (cmd.acc_add) begin
            acc_reg <= acc_sum[COUNT_W] ? CNT_MAX : acc_sum[COUNT_W-1:0];
            v_reg   <= v_reg + ADDR_W'(1);
            if (cmd.next_u) begin
                u_reg <= u_reg + ADDR_W'(1);
            end
        end
        if (cmd.load_out) begin
            count_reg <= acc_reg;
        end
    end

    assign stat.u_last = (u_reg == LAST_A);
    assign stat.v_last = (v_reg == LAST_A);
    assign count       = count_reg;

endmodule

`default_nettype wire

### rtl/core/gtc_ctrl.sv
// Controller: sequences edge loading, the counting walk and the result handoff.
// Depends on gtc_pkg; drives gtc_dpath through ctl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module gtc_ctrl
    import gtc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_last_edge,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_WR_B;
            ST_WR_B:    state_next = last_reg ? ST_ROW_RD : ST_IDLE;
            ST_ROW_RD:  state_next = ST_ROW_LD;
            ST_ROW_LD:  state_next = stat.u_last ? ST_FINISH : ST_COL_RD;
            ST_COL_RD:  state_next = ST_COL_AND;
            ST_COL_AND: state_next = ST_COL_ADD;
            ST_COL_ADD: state_next = stat.v_last ? ST_ROW_RD : ST_COL_RD;
            ST_FINISH:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.wr_in  = s_valid;
            end
            ST_WR_B: begin
                cmd.wr_back = 1'b1;
                cmd.start   = last_reg;
            end
            ST_ROW_RD:  cmd.rd_row = 1'b1;
            ST_ROW_LD:  cmd.ld_row = 1'b1;
            ST_COL_RD:  cmd.rd_col = 1'b1;
            ST_COL_AND: cmd.ld_and = 1'b1;
            ST_COL_ADD: begin
                cmd.acc_add = 1'b1;
                cmd.next_u  = stat.v_last;
            end
            ST_FINISH:  cmd.load_out = !m_valid_reg || m_ready;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        last_next = (state_reg == ST_IDLE && s_valid) ? s_last_edge : last_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### rtl/core/graph_triangle_counter_unit.sv
// Top level of the graph triangle counter: controller plus datapath.
// Depends on gtc_pkg, gtc_ctrl and gtc_dpath.
//
// channel | ports                                     | dir | transfer
// --------+-------------------------------------------+-----+-------------------
// edge    | s_node_a, s_node_b, s_last_edge           | in  | s_valid & s_ready
// count   | m_triangle_count                          | out | m_valid & m_ready
//
// An edge writes one row per endpoint (ST_IDLE, ST_WR_B) in the single-port row
// memory, and no new edge is taken until both are written. The walk reads each of
// R = min(NODE_COUNT, 64) rows, then reads, ANDs and adds each later column.
// Reset clears the row valid bits at once; no clearing pass. The matrix is
// cleared the same way when the count is loaded into the output register.
// Edges are taken while a count waits; a finished count waits for the slot.
`timescale 1ns / 1ps
`default_nettype none

module graph_triangle_counter_unit
    import gtc_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [VTX_W-1:0]   s_node_a,
    input  wire logic [VTX_W-1:0]   s_node_b,
    input  wire logic               s_last_edge,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COUNT_W-1:0]      m_triangle_count
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    gtc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_edge (s_last_edge),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    gtc_dpath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .node_a  (s_node_a),
        .node_b  (s_node_b),
        .count   (m_triangle_count)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input accepted on the cycle after an edge transfer");

    a_result_from_walk: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready)
    ) else $error("result raised without a finished count walk");
`endif

endmodule

`default_nettype wire

### sim/triangle_count_monitor.sv
// Count monitor for graph_triangle_counter_unit: watches both channels, rebuilds the
// adjacency matrix from accepted edges and compares every count. Depends on gtc_pkg.
`timescale 1ns / 1ps

module triangle_count_monitor
    import gtc_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [VTX_W-1:0]   s_node_a,
    input  logic [VTX_W-1:0]   s_node_b,
    input  logic               s_last_edge,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [COUNT_W-1:0] m_triangle_count,
    output int unsigned        mismatches,
    output int unsigned        counts_pending
);

    localparam int ROWS = (NODE_COUNT < MAX_ROWS) ? NODE_COUNT : MAX_ROWS;

    logic [MAX_ROWS-1:0] adj_rows [MAX_ROWS];
    logic [COUNT_W-1:0]  count_fifo [$];

    always @(posedge aclk) begin
        int unsigned        pair_sum;
        int unsigned        tri_total;
        logic [COUNT_W-1:0] want;
        if (!aresetn) begin
            foreach (adj_rows[r]) adj_rows[r] = '0;
            count_fifo.delete();
            mismatches <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (count_fifo.size() == 0) begin
                    $error("triangle_count: expected none, actual %0d", m_triangle_count);
                    mismatches <= mismatches + 1;
                end else begin
                    want = count_fifo.pop_front();
                    if (want !== m_triangle_count) begin
                        $error("triangle_count: expected %0d, actual %0d",
                               want, m_triangle_count);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_node_a != s_node_b && s_node_a < ROWS && s_node_b < ROWS) begin
                    adj_rows[s_node_a][s_node_b] = 1'b1;
                    adj_rows[s_node_b][s_node_a] = 1'b1;
                end
                if (s_last_edge) begin
                    // each triangle is seen once from each corner
                    pair_sum = 0;
                    for (int u = 0; u < ROWS; u++)
                        for (int v = 0; v < ROWS; v++)
                            if (adj_rows[u][v])
                                for (int w = v + 1; w < ROWS; w++)
                                    if (adj_rows[u][w] && adj_rows[v][w])
                                        pair_sum++;
                    tri_total = pair_sum / 3;
                    want = (tri_total > 65535) ? '1 : tri_total[COUNT_W-1:0];
                    count_fifo = {count_fifo, want};
                    foreach (adj_rows[r]) adj_rows[r] = '0;
                end
            end
        end
        counts_pending <= count_fifo.size();
    end

endmodule

### sim/testbench.sv
// Top of the triangle counter testbench: clock, reset, edge stimulus, count-side
// backpressure, watchdog and verdict. Depends on gtc_pkg, the unit and triangle_count_monitor.
`timescale 1ns / 1ps

module testbench;
    import gtc_pkg::*;

    localparam int EDGE_TARGET = 1450;
    localparam int MIN_GRAPHS  = 40;
    localparam int HOLD_CYCLES = 25000;
    localparam int IDLE_LIMIT  = 150000;
    localparam int DRAIN_WAIT  = 7000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [VTX_W-1:0]   s_node_a;
    logic [VTX_W-1:0]   s_node_b;
    logic               s_last_edge;
    logic               m_valid;
    logic               m_ready;
    logic [COUNT_W-1:0] m_triangle_count;

    int unsigned mismatches;
    int unsigned counts_pending;
    int unsigned idle_cycles = 0;
    int unsigned edges_sent  = 0;
    int unsigned graphs_sent = 0;
    bit          burst       = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_done    = 1'b0;

    always #1 aclk = ~aclk;

    graph_triangle_counter_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_node_a         (s_node_a),
        .s_node_b         (s_node_b),
        .s_last_edge      (s_last_edge),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_triangle_count (m_triangle_count)
    );

    triangle_count_monitor count_mon (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_node_a         (s_node_a),
        .s_node_b         (s_node_b),
        .s_last_edge      (s_last_edge),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_triangle_count (m_triangle_count),
        .mismatches       (mismatches),
        .counts_pending   (counts_pending)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    task automatic send_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                             input logic last);
        int unsigned gap;
        int unsigned roll;
        s_valid     <= 1'b1;
        s_node_a    <= a;
        s_node_b    <= b;
        s_last_edge <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        edges_sent++;
        if (last) graphs_sent++;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (!burst) begin
            if (roll >= 95)      gap = $urandom_range(8, 60);
            else if (roll >= 55) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // style 0: dense on a small vertex window, 1: uniform, 2: loops and repeats
    task automatic send_graph(input int style, input int n_edges, input int span);
        logic [VTX_W-1:0] base;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] prev_a;
        logic [VTX_W-1:0] prev_b;
        int unsigned      roll;
        base   = VTX_W'($urandom_range(0, 63));
        prev_a = base;
        prev_b = base + VTX_W'(1);
        for (int i = 0; i < n_edges; i++) begin
            roll = $urandom_range(0, 99);
            if (style == 1) begin
                a = VTX_W'($urandom_range(0, 63));
                b = VTX_W'($urandom_range(0, 63));
            end else begin
                a = base + VTX_W'($urandom_range(0, span - 1));
                b = base + VTX_W'($urandom_range(0, span - 1));
            end
            if (style == 2 && roll < 30) begin
                b = a;
            end else if (style == 2 && roll < 60) begin
                a = prev_b;
                b = prev_a;
            end else if (roll < 5) begin
                b = a;
            end
            prev_a = a;
            prev_b = b;
            send_edge(a, b, i == n_edges - 1);
        end
    endtask

    initial begin
        int unsigned        run_len;
        int unsigned        stall_len;
        int unsigned        roll;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 6);
            repeat (run_len) @(negedge aclk);
            roll = $urandom_range(0, 99);
            if (roll < 40)      stall_len = 0;
            else if (roll < 90) stall_len = $urandom_range(1, 4);
            else                stall_len = $urandom_range(20, 200);
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(negedge aclk);
            end
        end
    end

    initial begin
        logic [VTX_W-1:0] k5 [5];
        int unsigned      roll;
        int               style;
        int               random_graphs;
        k5 = '{6'd0, 6'd21, 6'd42, 6'd63, 6'd31};
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_node_a    = '0;
        s_node_b    = '0;
        s_last_edge = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty graph closed by a self loop
        send_edge(6'd5, 6'd5, 1'b1);
        // one triangle with a reversed repeat, a self loop and an open path through vertex 63
        send_edge(6'd0, 6'd1, 1'b0);
        send_edge(6'd1, 6'd2, 1'b0);
        send_edge(6'd2, 6'd0, 1'b0);
        send_edge(6'd1, 6'd0, 1'b0);
        send_edge(6'd2, 6'd2, 1'b0);
        send_edge(6'd63, 6'd0, 1'b0);
        send_edge(6'd62, 6'd63, 1'b1);
        // single edge between the extreme vertices
        send_edge(6'd0, 6'd63, 1'b1);
        // triangle at the top vertices
        send_edge(6'd63, 6'd62, 1'b0);
        send_edge(6'd62, 6'd61, 1'b0);
        send_edge(6'd61, 6'd63, 1'b1);
        // complete graph on five vertices
        for (int i = 0; i < 5; i++)
            for (int j = i + 1; j < 5; j++)
                send_edge(k5[i], k5[j], i == 3 && j == 4);

        s_valid <= 1'b0;
        wait (counts_pending == 0);
        @(negedge aclk);

        random_graphs = 0;
        while (edges_sent < EDGE_TARGET || graphs_sent < MIN_GRAPHS) begin
            burst = ($urandom_range(0, 4) == 0);
            if (random_graphs == 3) begin
                hold_request = 1'b1;
                for (int g = 0; g < 4; g++)
                    send_graph(0, $urandom_range(2, 5), 4);
                wait (hold_done);
                @(negedge aclk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 60)      style = 0;
            else if (roll < 85) style = 1;
            else if (roll < 95) style = 2;
            else                style = 3;
            if (style == 3)
                send_edge(VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)),
                          1'b1);
            else
                send_graph(style, $urandom_range(1, 40), $urandom_range(4, 12));
            random_graphs++;
            if (random_graphs % 9 == 0) begin
                s_valid <= 1'b0;
                wait (counts_pending == 0);
                @(negedge aclk);
            end
        end

        s_valid <= 1'b0;
        wait (counts_pending == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
